// ===== hw/rtl/gts_pkg.sv =====
// ----------------------------------------------------------------------------
// gts_pkg
// Types, register map and helper functions for the gimbal track/scan target
// selector.
// ----------------------------------------------------------------------------
package gts_pkg;

	localparam int ANGLE_W    = 16;
	localparam int LIM_W      = 15;
	localparam int STEP_W     = 31;
	localparam int PHASE_W    = 32;
	localparam int IDLE_W     = 10;
	localparam int SINE_W     = 15;
	localparam int APB_ADDR_W = 5;
	localparam int APB_DATA_W = 32;

	localparam logic [LIM_W-1:0]  RST_TRACK_PITCH_LIMIT = 15'd10752;
	localparam logic [LIM_W-1:0]  RST_TRACK_YAW_LIMIT   = 15'd11520;
	localparam logic [LIM_W-1:0]  RST_SCAN_PITCH_LIMIT  = 15'd10240;
	localparam logic [LIM_W-1:0]  RST_SCAN_YAW_LIMIT    = 15'd10752;
	localparam logic [LIM_W-1:0]  RST_SCAN_PITCH_AMP    = 15'd10240;
	localparam logic [LIM_W-1:0]  RST_SCAN_YAW_AMP      = 15'd11008;
	localparam logic [STEP_W-1:0] RST_YAW_PHASE_STEP    = 31'd1288490;
	localparam logic [STEP_W-1:0] RST_PITCH_PHASE_STEP  = 31'd5153961;

	typedef enum logic [2:0] {
		REG_TRACK_PITCH_LIMIT = 3'd0,
		REG_TRACK_YAW_LIMIT   = 3'd1,
		REG_SCAN_PITCH_LIMIT  = 3'd2,
		REG_SCAN_YAW_LIMIT    = 3'd3,
		REG_SCAN_PITCH_AMP    = 3'd4,
		REG_SCAN_YAW_AMP      = 3'd5,
		REG_YAW_PHASE_STEP    = 3'd6,
		REG_PITCH_PHASE_STEP  = 3'd7
	} reg_idx_t;

	// Symmetric clamp of a 17-bit signed value to +-lim.
	function automatic logic signed [ANGLE_W-1:0] clamp_sym(
		input logic signed [ANGLE_W:0] v,
		input logic [LIM_W-1:0] lim
	);
		logic signed [ANGLE_W:0] hi;
		logic signed [ANGLE_W:0] lo;
		hi = $signed({2'b00, lim});
		lo = -hi;
		if (v > hi) begin
			clamp_sym = hi[ANGLE_W-1:0];
		end else if (v < lo) begin
			clamp_sym = lo[ANGLE_W-1:0];
		end else begin
			clamp_sym = v[ANGLE_W-1:0];
		end
	endfunction

	// Quarter-wave sine entry in Q15 from the sample point x (Q16 radians
	// scaled by pi/2), evaluated with an odd polynomial at elaboration.
	function automatic logic [SINE_W-1:0] rom_entry(input longint x);
		longint x2;
		longint t;
		longint y;
		x2 = (x * x) >>> 16;
		t  = (64'sd5223 * x2) >>> 16;
		t  = 64'sd42334 - t;
		t  = (t * x2) >>> 16;
		t  = 64'sd102944 - t;
		y  = (x * t) >>> 16;
		y  = (y + 64'sd1) >>> 1;
		if (y > 64'sd32767) begin
			y = 64'sd32767;
		end
		rom_entry = y[SINE_W-1:0];
	endfunction

endpackage

// ===== hw/rtl/gts_tick_if.sv =====
// ----------------------------------------------------------------------------
// gts_tick_if
// Input channel: one item per control tick, optionally carrying a vision packet.
// ----------------------------------------------------------------------------
interface gts_tick_if;
	logic               valid;
	logic               ready;
	logic               packet_valid;
	logic signed [15:0] packet_pitch;
	logic signed [15:0] packet_yaw;

	modport source (output valid, output packet_valid, output packet_pitch,
		output packet_yaw, input ready);
	modport sink (input valid, input packet_valid, input packet_pitch,
		input packet_yaw, output ready);
endinterface

// ===== hw/rtl/gts_target_if.sv =====
// ----------------------------------------------------------------------------
// gts_target_if
// Output channel: gimbal angle targets and mode flags for one tick.
// ----------------------------------------------------------------------------
interface gts_target_if;
	logic               valid;
	logic               ready;
	logic signed [15:0] pitch_aim;
	logic signed [15:0] yaw_aim;
	logic               sentry_active;
	logic               clear_integrators;

	modport source (output valid, output pitch_aim, output yaw_aim,
		output sentry_active, output clear_integrators, input ready);
	modport sink (input valid, input pitch_aim, input yaw_aim,
		input sentry_active, input clear_integrators, output ready);
endinterface

// ===== hw/rtl/gimbal_track_or_scan_target.sv =====
// ----------------------------------------------------------------------------
// gimbal_track_or_scan_target
// Picks the gimbal angle targets each tick: clamped vision angles while
// tracking, or a two-axis sine scan after the vision link goes quiet.
// ----------------------------------------------------------------------------
//  channel  dir  handshake            payload
//  tick     in   valid/ready          packet_valid, packet_pitch, packet_yaw
//  target   out  valid/ready          pitch_aim, yaw_aim, sentry_active,
//                                     clear_integrators
//  apb      in   psel/penable/pready  8 registers at byte address 4*index
//
// One item per clock cycle unless the result stalls; input register, then result
// register. The scan sine index for each axis is precomputed when the phase
// advances, so the per-item path is one table read and one 15x15 multiply.
// Reset clears the mode state and loads the register defaults; no clearing
// pass. A stalled result holds in the result register while one more item
// waits in the input register.
// ----------------------------------------------------------------------------
module gimbal_track_or_scan_target #(
	parameter int LOST_TIMEOUT     = 200,
	parameter int SINE_TABLE_DEPTH = 256
) (
	input  logic                            clk,
	input  logic                            arst_n,
	gts_tick_if.sink                        tick,
	gts_target_if.source                    target,
	input  logic                            psel,
	input  logic                            penable,
	input  logic                            pwrite,
	input  logic [gts_pkg::APB_ADDR_W-1:0]  paddr,
	input  logic [gts_pkg::APB_DATA_W-1:0]  pwdata,
	output logic [gts_pkg::APB_DATA_W-1:0]  prdata,
	output logic                            pready
);
	import gts_pkg::*;

	localparam int IW = $clog2(SINE_TABLE_DEPTH);
	localparam int DW = $clog2(SINE_TABLE_DEPTH + 1);
	localparam int PW = 30 + DW;
	localparam logic [DW-1:0]     DEPTH_W = DW'(SINE_TABLE_DEPTH);
	localparam logic [IW-1:0]     IDX_MAX = IW'(SINE_TABLE_DEPTH - 1);
	localparam logic [IDLE_W-1:0] TIMEOUT = IDLE_W'(LOST_TIMEOUT);

	// Configuration registers.
	logic [LIM_W-1:0]  track_pitch_limit_q;
	logic [LIM_W-1:0]  track_yaw_limit_q;
	logic [LIM_W-1:0]  scan_pitch_limit_q;
	logic [LIM_W-1:0]  scan_yaw_limit_q;
	logic [LIM_W-1:0]  scan_pitch_amp_q;
	logic [LIM_W-1:0]  scan_yaw_amp_q;
	logic [STEP_W-1:0] yaw_phase_step_q;
	logic [STEP_W-1:0] pitch_phase_step_q;

	logic     cfg_wr;
	reg_idx_t cfg_idx;

	assign pready  = 1'b1;
	assign cfg_wr  = psel && penable && pwrite;
	assign cfg_idx = reg_idx_t'(paddr[4:2]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			track_pitch_limit_q <= RST_TRACK_PITCH_LIMIT;
			track_yaw_limit_q   <= RST_TRACK_YAW_LIMIT;
			scan_pitch_limit_q  <= RST_SCAN_PITCH_LIMIT;
			scan_yaw_limit_q    <= RST_SCAN_YAW_LIMIT;
			scan_pitch_amp_q    <= RST_SCAN_PITCH_AMP;
			scan_yaw_amp_q      <= RST_SCAN_YAW_AMP;
			yaw_phase_step_q    <= RST_YAW_PHASE_STEP;
			pitch_phase_step_q  <= RST_PITCH_PHASE_STEP;
		end else if (cfg_wr) begin
			case (cfg_idx)
				REG_TRACK_PITCH_LIMIT: track_pitch_limit_q <= pwdata[LIM_W-1:0];
				REG_TRACK_YAW_LIMIT:   track_yaw_limit_q   <= pwdata[LIM_W-1:0];
				REG_SCAN_PITCH_LIMIT:  scan_pitch_limit_q  <= pwdata[LIM_W-1:0];
				REG_SCAN_YAW_LIMIT:    scan_yaw_limit_q    <= pwdata[LIM_W-1:0];
				REG_SCAN_PITCH_AMP:    scan_pitch_amp_q    <= pwdata[LIM_W-1:0];
				REG_SCAN_YAW_AMP:      scan_yaw_amp_q      <= pwdata[LIM_W-1:0];
				REG_YAW_PHASE_STEP:    yaw_phase_step_q    <= pwdata[STEP_W-1:0];
				REG_PITCH_PHASE_STEP:  pitch_phase_step_q  <= pwdata[STEP_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (cfg_idx)
			REG_TRACK_PITCH_LIMIT: prdata = APB_DATA_W'(track_pitch_limit_q);
			REG_TRACK_YAW_LIMIT:   prdata = APB_DATA_W'(track_yaw_limit_q);
			REG_SCAN_PITCH_LIMIT:  prdata = APB_DATA_W'(scan_pitch_limit_q);
			REG_SCAN_YAW_LIMIT:    prdata = APB_DATA_W'(scan_yaw_limit_q);
			REG_SCAN_PITCH_AMP:    prdata = APB_DATA_W'(scan_pitch_amp_q);
			REG_SCAN_YAW_AMP:      prdata = APB_DATA_W'(scan_yaw_amp_q);
			REG_YAW_PHASE_STEP:    prdata = APB_DATA_W'(yaw_phase_step_q);
			REG_PITCH_PHASE_STEP:  prdata = APB_DATA_W'(pitch_phase_step_q);
			default:               prdata = '0;
		endcase
	end

	// Quarter-wave sine table, built from constants at elaboration.
	logic [SINE_W-1:0] sine_rom [SINE_TABLE_DEPTH];

	for (genvar g = 0; g < SINE_TABLE_DEPTH; g++) begin : g_rom
		localparam int X = ((2 * g + 1) * 65536) / (2 * SINE_TABLE_DEPTH);
		assign sine_rom[g] = rom_entry(longint'(X));
	end

	// Input register and handshake.
	logic                     valid_s1;
	logic                     pkt_valid_s1;
	logic signed [ANGLE_W-1:0] pkt_pitch_s1;
	logic signed [ANGLE_W-1:0] pkt_yaw_s1;
	logic                     out_valid_q;
	logic                     advance;

	assign advance    = valid_s1 && (!out_valid_q || target.ready);
	assign tick.ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (tick.ready) begin
			valid_s1 <= tick.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (tick.valid && tick.ready) begin
			pkt_valid_s1 <= tick.packet_valid;
			pkt_pitch_s1 <= tick.packet_pitch;
			pkt_yaw_s1   <= tick.packet_yaw;
		end
	end

	// Mode state.
	logic                      tracking_q;
	logic                      scan_q;
	logic [IDLE_W-1:0]         idle_q;
	logic signed [ANGLE_W-1:0] held_pitch_q;
	logic signed [ANGLE_W-1:0] held_yaw_q;
	logic [PHASE_W-1:0]        pitch_phase_q;
	logic [PHASE_W-1:0]        yaw_phase_q;
	logic                      pitch_neg_q;
	logic                      yaw_neg_q;
	logic [IW-1:0]             pitch_idx_q;
	logic [IW-1:0]             yaw_idx_q;

	logic                      tracking_d;
	logic                      scan_d;
	logic [IDLE_W-1:0]         idle_d;
	logic [IDLE_W-1:0]         idle_inc;
	logic signed [ANGLE_W-1:0] held_pitch_d;
	logic signed [ANGLE_W-1:0] held_yaw_d;
	logic                      clr_d;

	always_comb begin
		tracking_d   = tracking_q;
		scan_d       = scan_q;
		idle_d       = idle_q;
		held_pitch_d = held_pitch_q;
		held_yaw_d   = held_yaw_q;
		clr_d        = 1'b0;
		idle_inc     = (idle_q < TIMEOUT) ? idle_q + IDLE_W'(1) : idle_q;
		if (pkt_valid_s1) begin
			clr_d        = !tracking_q;
			tracking_d   = 1'b1;
			scan_d       = 1'b0;
			idle_d       = '0;
			held_pitch_d = clamp_sym({pkt_pitch_s1[ANGLE_W-1], pkt_pitch_s1},
				track_pitch_limit_q);
			held_yaw_d   = clamp_sym({pkt_yaw_s1[ANGLE_W-1], pkt_yaw_s1},
				track_yaw_limit_q);
		end else begin
			idle_d = idle_inc;
			// Once the link has been quiet long enough, every further quiet
			// tick restarts the loops and parks the held angles at zero.
			if (idle_inc >= TIMEOUT) begin
				scan_d       = 1'b1;
				tracking_d   = 1'b0;
				held_pitch_d = '0;
				held_yaw_d   = '0;
				clr_d        = 1'b1;
			end
		end
	end

	// Table index for a phase, with the mirror for odd quadrants folded in.
	function automatic logic [IW-1:0] phase_index(input logic [PHASE_W-1:0] ph);
		logic [PW-1:0] prod;
		logic [IW-1:0] raw;
		prod = PW'(ph[29:0]) * PW'(DEPTH_W);
		raw  = prod[30 +: IW];
		phase_index = ph[30] ? IDX_MAX - raw : raw;
	endfunction

	logic [PHASE_W-1:0] pitch_phase_d;
	logic [PHASE_W-1:0] yaw_phase_d;

	assign pitch_phase_d = scan_d ? pitch_phase_q + PHASE_W'(pitch_phase_step_q) : '0;
	assign yaw_phase_d   = scan_d ? yaw_phase_q + PHASE_W'(yaw_phase_step_q) : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tracking_q    <= 1'b0;
			scan_q        <= 1'b0;
			idle_q        <= '0;
			held_pitch_q  <= '0;
			held_yaw_q    <= '0;
			pitch_phase_q <= '0;
			yaw_phase_q   <= '0;
			pitch_neg_q   <= 1'b0;
			yaw_neg_q     <= 1'b0;
			pitch_idx_q   <= '0;
			yaw_idx_q     <= '0;
		end else if (advance) begin
			tracking_q    <= tracking_d;
			scan_q        <= scan_d;
			idle_q        <= idle_d;
			held_pitch_q  <= held_pitch_d;
			held_yaw_q    <= held_yaw_d;
			pitch_phase_q <= pitch_phase_d;
			yaw_phase_q   <= yaw_phase_d;
			pitch_neg_q   <= pitch_phase_d[31];
			yaw_neg_q     <= yaw_phase_d[31];
			pitch_idx_q   <= phase_index(pitch_phase_d);
			yaw_idx_q     <= phase_index(yaw_phase_d);
		end
	end

	// Scan values from the phases before they advance.
	logic [2*LIM_W:0]          pitch_prod;
	logic [2*LIM_W:0]          yaw_prod;
	logic signed [ANGLE_W:0]   pitch_sine;
	logic signed [ANGLE_W:0]   yaw_sine;
	logic signed [ANGLE_W-1:0] pitch_out;
	logic signed [ANGLE_W-1:0] yaw_out;

	always_comb begin
		pitch_prod = (2*LIM_W+1)'(scan_pitch_amp_q) * (2*LIM_W+1)'(sine_rom[pitch_idx_q])
			+ (2*LIM_W+1)'(16384);
		yaw_prod   = (2*LIM_W+1)'(scan_yaw_amp_q) * (2*LIM_W+1)'(sine_rom[yaw_idx_q])
			+ (2*LIM_W+1)'(16384);
		pitch_sine = $signed({1'b0, pitch_prod[30:15]});
		yaw_sine   = $signed({1'b0, yaw_prod[30:15]});
		if (pitch_neg_q) begin
			pitch_sine = -pitch_sine;
		end
		if (yaw_neg_q) begin
			yaw_sine = -yaw_sine;
		end
		if (scan_d) begin
			pitch_out = clamp_sym(pitch_sine, scan_pitch_limit_q);
			yaw_out   = clamp_sym(yaw_sine, scan_yaw_limit_q);
		end else begin
			pitch_out = clamp_sym({held_pitch_d[ANGLE_W-1], held_pitch_d},
				track_pitch_limit_q);
			yaw_out   = clamp_sym({held_yaw_d[ANGLE_W-1], held_yaw_d},
				track_yaw_limit_q);
		end
	end

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (target.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	logic signed [ANGLE_W-1:0] pitch_aim_q;
	logic signed [ANGLE_W-1:0] yaw_aim_q;
	logic                      sentry_q;
	logic                      clr_q;

	always_ff @(posedge clk) begin
		if (advance) begin
			pitch_aim_q <= pitch_out;
			yaw_aim_q   <= yaw_out;
			sentry_q    <= scan_d;
			clr_q       <= clr_d;
		end
	end

	assign target.valid             = out_valid_q;
	assign target.pitch_aim         = pitch_aim_q;
	assign target.yaw_aim           = yaw_aim_q;
	assign target.sentry_active     = sentry_q;
	assign target.clear_integrators = clr_q;

	// Checks.
	a_mode_exclusive: assert property (@(posedge clk) disable iff (!arst_n)
		!(tracking_q && scan_q))
		else $error("tracking and scan mode set together");

	a_idle_saturates: assert property (@(posedge clk) disable iff (!arst_n)
		idle_q <= TIMEOUT)
		else $error("idle tick count ran past the timeout");

	a_phase_parked: assert property (@(posedge clk) disable iff (!arst_n)
		!scan_q |-> (pitch_phase_q == '0 && yaw_phase_q == '0 &&
			pitch_idx_q == '0 && yaw_idx_q == '0))
		else $error("scan phase not parked outside scan mode");

	a_packet_tracks: assert property (@(posedge clk) disable iff (!arst_n)
		advance && pkt_valid_s1 |=> tracking_q && !scan_q && idle_q == '0)
		else $error("packet did not switch to tracking");

	a_result_mode: assert property (@(posedge clk) disable iff (!arst_n)
		advance |=> target.sentry_active == scan_q)
		else $error("result mode flag disagrees with scan state");

endmodule
